/* src/csc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csc_pkg: shared types and constants for the coil sensitivity combiner
// Field widths, accumulator widths, the sequencer state type and the
// operation codes of the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package csc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int ACC_W    = 38;
    localparam int ROOT_W   = ACC_W / 2;
    localparam int PIX_W    = 19;
    localparam int SQRT_CW  = $clog2(ROOT_W);
    localparam int DIV_CW   = $clog2(ACC_W);

    localparam logic [ACC_W-1:0] PIX_POS_LIMIT = ACC_W'((1 << (PIX_W - 1)) - 1);
    localparam logic [ACC_W-1:0] PIX_NEG_LIMIT = ACC_W'(1 << (PIX_W - 1));
    localparam logic signed [PIX_W-1:0] PIX_MAX = PIX_W'((1 << (PIX_W - 1)) - 1);
    localparam logic signed [PIX_W-1:0] PIX_MIN = PIX_W'(1 << (PIX_W - 1));

    typedef enum logic [2:0] {
        MAC_RR,
        MAC_II,
        MAC_IR,
        MAC_RI,
        MAC_NR,
        MAC_NI
    } mac_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_SQRT,
        ST_DIV_RE,
        ST_DIV_IM,
        ST_FINISH
    } state_t;

endpackage : csc_pkg
`default_nettype wire

/* src/csc_mac.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csc_mac: shared multiply-accumulate unit
// One 16x16 multiplier stepped through six products per channel; the
// registered product is added into the complex sum or the norm sum.
// ----------------------------------------------------------------------------
module csc_mac (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic                                clear,
    input  wire logic signed [csc_pkg::SAMPLE_W-1:0] sample_re,
    input  wire logic signed [csc_pkg::SAMPLE_W-1:0] sample_im,
    input  wire logic signed [csc_pkg::SAMPLE_W-1:0] sens_re,
    input  wire logic signed [csc_pkg::SAMPLE_W-1:0] sens_im,
    output logic                                     done,
    output logic signed [csc_pkg::ACC_W-1:0]         acc_re,
    output logic signed [csc_pkg::ACC_W-1:0]         acc_im,
    output logic        [csc_pkg::ACC_W-1:0]         norm
);
    import csc_pkg::*;

    logic signed [SAMPLE_W-1:0] sr_reg, si_reg, cr_reg, ci_reg;
    logic                       run_reg;
    mac_op_t                    op_reg;
    mac_op_t                    pop_reg;
    logic                       pvld_reg;
    logic                       done_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_re_reg, acc_im_reg;
    logic        [ACC_W-1:0]    norm_reg;

    logic signed [SAMPLE_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [ACC_W-1:0]    prod_ext;
    mac_op_t                    op_next;

    always_comb begin
        case (op_reg)
            MAC_RR: begin mul_a = sr_reg; mul_b = cr_reg; op_next = MAC_II; end
            MAC_II: begin mul_a = si_reg; mul_b = ci_reg; op_next = MAC_IR; end
            MAC_IR: begin mul_a = si_reg; mul_b = cr_reg; op_next = MAC_RI; end
            MAC_RI: begin mul_a = sr_reg; mul_b = ci_reg; op_next = MAC_NR; end
            MAC_NR: begin mul_a = cr_reg; mul_b = cr_reg; op_next = MAC_NI; end
            MAC_NI: begin mul_a = ci_reg; mul_b = ci_reg; op_next = MAC_NI; end
            default: begin mul_a = sr_reg; mul_b = cr_reg; op_next = MAC_RR; end
        endcase
        mul_p    = mul_a * mul_b;
        prod_ext = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sr_reg <= sample_re;
            si_reg <= sample_im;
            cr_reg <= sens_re;
            ci_reg <= sens_im;
        end
        if (run_reg) begin
            prod_reg <= mul_p;
            pop_reg  <= op_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            op_reg   <= MAC_RR;
            pvld_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            pvld_reg <= run_reg;
            done_reg <= pvld_reg && (pop_reg == MAC_NI);
            if (start) begin
                run_reg <= 1'b1;
                op_reg  <= MAC_RR;
            end else if (run_reg) begin
                op_reg <= op_next;
                if (op_reg == MAC_NI) begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
            norm_reg   <= '0;
        end else if (pvld_reg) begin
            case (pop_reg)
                MAC_RR, MAC_II: acc_re_reg <= acc_re_reg + prod_ext;
                MAC_IR:         acc_im_reg <= acc_im_reg + prod_ext;
                MAC_RI:         acc_im_reg <= acc_im_reg - prod_ext;
                MAC_NR, MAC_NI: norm_reg   <= norm_reg + ACC_W'(unsigned'(prod_ext));
                default:        acc_re_reg <= acc_re_reg;
            endcase
        end
    end

    assign done   = done_reg;
    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;
    assign norm   = norm_reg;

endmodule : csc_mac
`default_nettype wire

/* src/csc_sqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csc_sqrt: iterative integer square root
// Digit-by-digit floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module csc_sqrt (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [csc_pkg::ACC_W-1:0]    radicand,
    output logic                              done,
    output logic      [csc_pkg::ROOT_W-1:0]   root
);
    import csc_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int SH_W  = REM_W + 2;

    logic                run_reg;
    logic                done_reg;
    logic [SQRT_CW-1:0]  cnt_reg;
    logic [ACC_W-1:0]    rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;

    logic [SH_W-1:0]     rem_sh;
    logic [SH_W-1:0]     trial;
    logic                ge;
    logic [SH_W-1:0]     rem_diff;

    always_comb begin
        rem_sh   = {rem_reg, rad_reg[ACC_W-1 -: 2]};
        trial    = {2'b00, root_reg, 2'b01};
        ge       = rem_sh >= trial;
        rem_diff = ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (run_reg) begin
            rad_reg  <= {rad_reg[ACC_W-3:0], 2'b00};
            rem_reg  <= rem_diff[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= SQRT_CW'(ROOT_W - 1);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule : csc_sqrt
`default_nettype wire

/* src/csc_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csc_div: iterative signed divide with saturation
// Restoring divide of a signed sum by the root, one quotient bit per cycle,
// truncating toward zero and clamping to the pixel range.
// ----------------------------------------------------------------------------
module csc_div (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic signed [csc_pkg::ACC_W-1:0]    dividend,
    input  wire logic        [csc_pkg::ROOT_W-1:0]   divisor,
    output logic                                     done,
    output logic signed [csc_pkg::PIX_W-1:0]         quot,
    output logic                                     sat
);
    import csc_pkg::*;

    logic                run_reg;
    logic                done_reg;
    logic [DIV_CW-1:0]   cnt_reg;
    logic                neg_reg;
    logic [ACC_W-1:0]    dvd_reg;
    logic [ROOT_W-1:0]   den_reg;
    logic [ROOT_W-1:0]   rem_reg;

    logic [ACC_W-1:0]    mag;
    logic [ROOT_W:0]     rem_sh;
    logic                ge;
    logic [ROOT_W:0]     rem_diff;
    logic [PIX_W-1:0]    q_low;

    always_comb begin
        mag      = dividend[ACC_W-1] ? (~unsigned'(dividend) + 1'b1) : unsigned'(dividend);
        rem_sh   = {rem_reg, dvd_reg[ACC_W-1]};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_diff = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
        q_low    = dvd_reg[PIX_W-1:0];
        if (neg_reg) begin
            sat  = dvd_reg > PIX_NEG_LIMIT;
            quot = sat ? PIX_MIN : signed'(~q_low + 1'b1);
        end else begin
            sat  = dvd_reg > PIX_POS_LIMIT;
            quot = sat ? PIX_MAX : signed'(q_low);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[ACC_W-1];
            dvd_reg <= mag;
            den_reg <= divisor;
            rem_reg <= '0;
        end else if (run_reg) begin
            dvd_reg <= {dvd_reg[ACC_W-2:0], ge};
            rem_reg <= rem_diff[ROOT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= DIV_CW'(ACC_W - 1);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;

endmodule : csc_div
`default_nettype wire

/* src/coil_sensitivity_combine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// coil_sensitivity_combine: sensitivity-weighted complex coil combination
// Accepts one item per coil channel on s_ (sample and Q1.15 sensitivity).
// Each channel runs six products through one shared multiplier: s_ready
// stays low until they are summed, so a channel is taken only once the
// last one is through. An item with s_last_channel ends the pixel: a
// square root of the norm, then divides of the two complex sums by the
// root, which a zero norm skips; the products are skipped when the last
// channel is an excess one.
// Channels beyond CHANNELS are dropped from the sums and flag overflow;
// saturated parts also flag overflow. A zero norm gives a zero pixel and
// m_zero_norm. The result waits in an output register: the next pixel's
// channels are accepted while it stalls, and the block only holds at the
// end of the next pixel until m_ready takes the waiting item.
// Reset (aresetn low, synchronous) clears the sums, the channel count and
// the output valid.
// ----------------------------------------------------------------------------
module coil_sensitivity_combine #(
    parameter int CHANNELS = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [csc_pkg::SAMPLE_W-1:0]  s_sample_re,
    input  wire logic signed [csc_pkg::SAMPLE_W-1:0]  s_sample_im,
    input  wire logic signed [csc_pkg::SAMPLE_W-1:0]  s_sens_re,
    input  wire logic signed [csc_pkg::SAMPLE_W-1:0]  s_sens_im,
    input  wire logic                                 s_last_channel,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [csc_pkg::PIX_W-1:0]          m_pixel_re,
    output logic signed [csc_pkg::PIX_W-1:0]          m_pixel_im,
    output logic                                      m_zero_norm,
    output logic                                      m_overflow
);
    import csc_pkg::*;

    localparam int CNT_W = $clog2(CHANNELS + 1);

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    excess_reg;
    logic                    last_reg;
    logic signed [PIX_W-1:0] pix_re_reg;
    logic                    sat_re_reg;
    logic                    m_valid_reg;
    logic signed [PIX_W-1:0] m_pixel_re_reg, m_pixel_im_reg;
    logic                    m_zero_reg, m_ovf_reg;

    logic                    accept;
    logic                    excess_hit;
    logic                    out_free;
    logic                    root_zero;
    logic                    mac_start, mac_done;
    logic                    sqrt_start, sqrt_done;
    logic                    div_start, div_done, div_sel_im;
    logic                    cap_re, out_load;
    logic signed [ACC_W-1:0] acc_re, acc_im;
    logic        [ACC_W-1:0] norm;
    logic        [ROOT_W-1:0] root;
    logic signed [PIX_W-1:0] div_quot;
    logic                    div_sat;

    csc_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mac_start),
        .clear     (out_load),
        .sample_re (s_sample_re),
        .sample_im (s_sample_im),
        .sens_re   (s_sens_re),
        .sens_im   (s_sens_im),
        .done      (mac_done),
        .acc_re    (acc_re),
        .acc_im    (acc_im),
        .norm      (norm)
    );

    csc_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (norm),
        .done     (sqrt_done),
        .root     (root)
    );

    csc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_sel_im ? acc_im : acc_re),
        .divisor  (root),
        .done     (div_done),
        .quot     (div_quot),
        .sat      (div_sat)
    );

    assign accept     = s_valid && s_ready;
    assign excess_hit = cnt_reg >= CNT_W'(CHANNELS);
    assign out_free   = !m_valid_reg || m_ready;
    assign root_zero  = root == '0;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!excess_hit) begin
                        state_next = ST_MAC;
                    end else if (s_last_channel) begin
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_MAC: begin
                if (mac_done) begin
                    state_next = last_reg ? ST_SQRT : ST_IDLE;
                end
            end
            ST_SQRT: begin
                if (sqrt_done) begin
                    state_next = root_zero ? ST_FINISH : ST_DIV_RE;
                end
            end
            ST_DIV_RE: begin
                if (div_done) begin
                    state_next = ST_DIV_IM;
                end
            end
            ST_DIV_IM: begin
                if (div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = state_reg == ST_IDLE;
        mac_start  = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        div_sel_im = 1'b0;
        cap_re     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                mac_start  = accept && !excess_hit;
                sqrt_start = accept && excess_hit && s_last_channel;
            end
            ST_MAC: begin
                sqrt_start = mac_done && last_reg;
            end
            ST_SQRT: begin
                div_start = sqrt_done && !root_zero;
            end
            ST_DIV_RE: begin
                div_start  = div_done;
                div_sel_im = 1'b1;
                cap_re     = div_done;
            end
            ST_FINISH: begin
                out_load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            last_reg <= s_last_channel;
        end
        if (cap_re) begin
            pix_re_reg <= div_quot;
            sat_re_reg <= div_sat;
        end
        if (out_load) begin
            m_pixel_re_reg <= root_zero ? '0 : pix_re_reg;
            m_pixel_im_reg <= root_zero ? '0 : div_quot;
            m_zero_reg     <= root_zero;
            m_ovf_reg      <= excess_reg || (!root_zero && (sat_re_reg || div_sat));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            excess_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                cnt_reg    <= '0;
                excess_reg <= 1'b0;
            end else if (accept) begin
                if (excess_hit) begin
                    excess_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pixel_re  = m_pixel_re_reg;
    assign m_pixel_im  = m_pixel_im_reg;
    assign m_zero_norm = m_zero_reg;
    assign m_overflow  = m_ovf_reg;

endmodule : coil_sensitivity_combine
`default_nettype wire
